// ----- src/lkv_pkg.sv -----
package lkv_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int RANK_W  = IDX_W;
  localparam int OCC_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;
  localparam int ADDR_W  = 3;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = ADDR_W - 2;

  localparam logic [CAP_W-1:0]     CAPACITY_RESET = CAP_W'(16);
  localparam logic [REG_IDX_W-1:0] REG_CAPACITY   = REG_IDX_W'(0);

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic               is_get;
    logic               out_free;
    logic [OCC_W-1:0]   occupancy;
    logic [ENTRIES-1:0] match;
  } status_t;

endpackage

// ----- src/lkv_ctrl.sv -----
module lkv_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  lkv_pkg::status_t status,
  output lkv_pkg::cmd_t    cmd
);

  lkv_pkg::state_t state;
  lkv_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lkv_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    s_tready    = 1'b0;
    case (state)
      lkv_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = lkv_pkg::ST_EXEC;
        end
      end
      lkv_pkg::ST_EXEC: begin
        // hold a get until the result register can take its beat
        if (!status.is_get || status.out_free) begin
          cmd.commit = 1'b1;
          state_next = lkv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lkv_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/lkv_datapath.sv -----
module lkv_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  lkv_pkg::cmd_t                        cmd,
  input  logic [lkv_pkg::KEY_W+lkv_pkg::VAL_W-1:0] s_tdata,
  input  logic                                 s_tuser,
  input  logic [lkv_pkg::CAP_W-1:0]            capacity,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [lkv_pkg::VAL_W-1:0]            m_tdata,
  output logic                                 m_tuser,
  output lkv_pkg::status_t                     status
);

  localparam int N = lkv_pkg::ENTRIES;

  logic [N-1:0]                     slot_valid;
  logic [lkv_pkg::KEY_W-1:0]        slot_key   [N];
  logic [lkv_pkg::VAL_W-1:0]        slot_value [N];
  logic [lkv_pkg::RANK_W-1:0]       slot_rank  [N];
  logic [lkv_pkg::OCC_W-1:0]        occupancy;

  lkv_pkg::op_t                     op_q;
  logic [lkv_pkg::KEY_W-1:0]        key_q;
  logic [lkv_pkg::VAL_W-1:0]        value_q;
  logic [N-1:0]                     match_q;

  logic                             out_valid;
  logic                             out_hit;
  logic [lkv_pkg::VAL_W-1:0]        out_data;

  logic [N-1:0]                     match_now;
  logic                             hit;
  logic [lkv_pkg::RANK_W-1:0]       hit_rank;
  logic [lkv_pkg::VAL_W-1:0]        hit_value;
  logic [lkv_pkg::OCC_W-1:0]        eff_cap;
  logic                             need_evict;
  logic [lkv_pkg::RANK_W-1:0]       oldest_rank;
  logic [N-1:0]                     evict_vec;
  logic [N-1:0]                     keep_vec;
  logic [N-1:0]                     free_vec;

  // tag compare against the incoming key, registered at the accept edge
  always_comb begin
    for (int i = 0; i < N; i++) begin
      match_now[i] = slot_valid[i] && (slot_key[i] == s_tdata[lkv_pkg::KEY_W-1:0]);
    end
  end

  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < N; i++) begin
      if (match_q[i]) begin
        hit_rank  = hit_rank | slot_rank[i];
        hit_value = hit_value | slot_value[i];
      end
    end
  end

  assign hit = |match_q;

  always_comb begin
    if (capacity == '0) begin
      eff_cap = lkv_pkg::OCC_W'(1);
    end else if (lkv_pkg::OCC_W'(capacity) > lkv_pkg::OCC_W'(N)) begin
      eff_cap = lkv_pkg::OCC_W'(N);
    end else begin
      eff_cap = lkv_pkg::OCC_W'(capacity);
    end
  end

  // ranks of valid slots are always 0..occupancy-1, so the oldest is unique
  assign need_evict  = (op_q == lkv_pkg::OP_PUT) && !hit && (occupancy >= eff_cap);
  assign oldest_rank = lkv_pkg::RANK_W'(occupancy - lkv_pkg::OCC_W'(1));

  always_comb begin
    for (int i = 0; i < N; i++) begin
      evict_vec[i] = need_evict && slot_valid[i] && (slot_rank[i] == oldest_rank);
    end
  end

  assign keep_vec = slot_valid & ~evict_vec;
  // lowest free slot: lowest zero bit of keep_vec
  assign free_vec = ~keep_vec & (keep_vec + N'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      occupancy  <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < N; i++) begin
        slot_rank[i] <= '0;
      end
    end else begin
      if (cmd.commit) begin
        if (hit) begin
          for (int i = 0; i < N; i++) begin
            if (match_q[i]) begin
              slot_rank[i] <= '0;
            end else if (slot_valid[i] && (slot_rank[i] < hit_rank)) begin
              slot_rank[i] <= slot_rank[i] + lkv_pkg::RANK_W'(1);
            end
          end
        end else if (op_q == lkv_pkg::OP_PUT) begin
          for (int i = 0; i < N; i++) begin
            if (free_vec[i]) begin
              slot_valid[i] <= 1'b1;
              slot_rank[i]  <= '0;
            end else if (evict_vec[i]) begin
              slot_valid[i] <= 1'b0;
              slot_rank[i]  <= '0;
            end else if (keep_vec[i]) begin
              slot_rank[i] <= slot_rank[i] + lkv_pkg::RANK_W'(1);
            end
          end
          if (!need_evict) begin
            occupancy <= occupancy + lkv_pkg::OCC_W'(1);
          end
        end
      end
      if (cmd.commit && (op_q == lkv_pkg::OP_GET)) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= lkv_pkg::op_t'(s_tuser);
      key_q   <= s_tdata[lkv_pkg::KEY_W-1:0];
      value_q <= s_tdata[lkv_pkg::KEY_W+lkv_pkg::VAL_W-1:lkv_pkg::KEY_W];
      match_q <= match_now;
    end
    if (cmd.commit) begin
      if (op_q == lkv_pkg::OP_PUT) begin
        for (int i = 0; i < N; i++) begin
          if (hit ? match_q[i] : free_vec[i]) begin
            slot_value[i] <= value_q;
          end
          if (!hit && free_vec[i]) begin
            slot_key[i] <= key_q;
          end
        end
      end else begin
        out_hit  <= hit;
        out_data <= hit ? hit_value : '1;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_hit;

  assign status.is_get    = (op_q == lkv_pkg::OP_GET);
  assign status.out_free  = !out_valid || m_tready;
  assign status.occupancy = occupancy;
  assign status.match     = match_q;

endmodule

// ----- src/lru_key_value_cache.sv -----
// Fully associative LRU key/value cache with 16 entries. A get or put is
// accepted on the slave stream when the cache is idle; in the accept cycle
// the key is compared against all 16 stored keys and the match is
// registered; the execute state then updates the recency ranks, replacement
// and value store, and the next item is accepted only after that update.
// A get produces one beat on the master stream (tuser = hit, tdata = value
// or all ones on a miss); a put produces none. A get stays in its update
// cycle while the previous result beat is still untaken. The capacity
// register (byte address 0, reset 16) sets how many entries fill before the
// least recent one is evicted; 0 acts as 1 and values above 16 act as 16.
// No clearing pass runs after reset.
module lru_key_value_cache (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [lkv_pkg::KEY_W+lkv_pkg::VAL_W-1:0] s_tdata,  // key, value
  input  logic                                 s_tuser,  // operation
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [lkv_pkg::VAL_W-1:0]            m_tdata,  // data
  output logic                                 m_tuser,  // hit
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lkv_pkg::ADDR_W-1:0]           paddr,
  input  logic [lkv_pkg::PDATA_W-1:0]          pwdata,
  output logic [lkv_pkg::PDATA_W-1:0]          prdata,
  output logic                                 pready
);

  logic [lkv_pkg::CAP_W-1:0] capacity;
  logic                      reg_sel;
  lkv_pkg::cmd_t             cmd;
  lkv_pkg::status_t          status;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[lkv_pkg::ADDR_W-1:2] == lkv_pkg::REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkv_pkg::CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      capacity <= pwdata[lkv_pkg::CAP_W-1:0];
    end
  end

  assign prdata = reg_sel ? lkv_pkg::PDATA_W'(capacity) : '0;

  lkv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lkv_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .capacity (capacity),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .status   (status)
  );

  property p_miss_data;
    @(posedge clk) disable iff (rst) (m_tvalid && !m_tuser) |-> (m_tdata == '1);
  endproperty
  a_miss_data: assert property (p_miss_data) else $error("miss beat without all-ones data");

  property p_occ_bound;
    @(posedge clk) disable iff (rst)
      status.occupancy <= lkv_pkg::OCC_W'(lkv_pkg::ENTRIES);
  endproperty
  a_occ_bound: assert property (p_occ_bound) else $error("occupancy above entry count");

  // the match vector is only meaningful once a beat has been captured
  property p_unique_key;
    @(posedge clk) disable iff (rst) (s_tvalid && s_tready) |=> $onehot0(status.match);
  endproperty
  a_unique_key: assert property (p_unique_key) else $error("key stored in two slots");

  property p_one_at_a_time;
    @(posedge clk) disable iff (rst) (s_tvalid && s_tready) |=> !s_tready;
  endproperty
  a_one_at_a_time: assert property (p_one_at_a_time) else $error("accepted while busy");

endmodule

// ----- bench/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [lkv_pkg::VAL_W-1:0] MISS_DATA = '1;  // data returned by a get that misses
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;

  typedef struct packed {
    logic                      hit;
    logic [lkv_pkg::VAL_W-1:0] data;
  } lookup_t;

  typedef struct packed {
    lkv_pkg::op_t              op;
    logic [lkv_pkg::KEY_W-1:0] key;
    logic [lkv_pkg::VAL_W-1:0] val;
    bit                        typed;
    logic                      hit;
    logic [lkv_pkg::VAL_W-1:0] data;
  } access_t;

  localparam int SCRIPT_LEN = 17;
  localparam access_t SCRIPT [0:SCRIPT_LEN-1] = '{
    '{lkv_pkg::OP_GET, 32'h0000_0000, 32'h1234_5678, 1'b1, 1'b0, MISS_DATA},
    '{lkv_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{lkv_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF},
    '{lkv_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{lkv_pkg::OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h8000_0000},
    // a stored -1 must still report a hit
    '{lkv_pkg::OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{lkv_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{lkv_pkg::OP_GET, 32'hFFFF_FFFE, 32'h0000_0000, 1'b1, 1'b0, MISS_DATA},
    '{lkv_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{lkv_pkg::OP_GET, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000},
    '{lkv_pkg::OP_PUT, 32'h8000_0000, 32'h0000_0005, 1'b0, 1'b0, 32'h0},
    '{lkv_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0005},
    '{lkv_pkg::OP_GET, 32'h7FFF_FFFF, 32'h5555_5555, 1'b0, 1'b0, 32'h0},
    '{lkv_pkg::OP_PUT, 32'h0000_0001, 32'hA5A5_A5A5, 1'b0, 1'b0, 32'h0},
    '{lkv_pkg::OP_PUT, 32'h0000_0001, 32'h5A5A_5A5A, 1'b0, 1'b0, 32'h0},
    '{lkv_pkg::OP_GET, 32'h0000_0001, 32'h0000_0000, 1'b1, 1'b1, 32'h5A5A_5A5A},
    '{lkv_pkg::OP_GET, 32'h0000_0002, 32'h0000_0000, 1'b1, 1'b0, MISS_DATA}
  };

  logic                                     clk = 1'b0;
  logic                                     rst;
  logic                                     s_tvalid;
  logic                                     s_tready;
  logic [lkv_pkg::KEY_W+lkv_pkg::VAL_W-1:0] s_tdata;  // key, value
  logic                                     s_tuser;  // operation
  logic                                     m_tvalid;
  logic                                     m_tready;
  logic [lkv_pkg::VAL_W-1:0]                m_tdata;  // data
  logic                                     m_tuser;  // hit
  logic                                     psel;
  logic                                     penable;
  logic                                     pwrite;
  logic [lkv_pkg::ADDR_W-1:0]               paddr;
  logic [lkv_pkg::PDATA_W-1:0]              pwdata;
  logic [lkv_pkg::PDATA_W-1:0]              prdata;
  logic                                     pready;

  lru_key_value_cache dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // shadow of the cache contents
  logic                      line_valid [lkv_pkg::ENTRIES];
  logic [lkv_pkg::KEY_W-1:0] line_key   [lkv_pkg::ENTRIES];
  logic [lkv_pkg::VAL_W-1:0] line_val   [lkv_pkg::ENTRIES];
  int unsigned               line_rank  [lkv_pkg::ENTRIES];
  int unsigned               line_count;
  logic [lkv_pkg::CAP_W-1:0] capacity_reg;

  lookup_t                   pending_lookups [$];
  logic [lkv_pkg::KEY_W-1:0] key_pool [20];
  int                        fault_count = 0;
  bit                        steady = 1'b0;
  bit                        hold_req = 1'b0;
  int                        stall_cycles = 0;

  task automatic log_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%s", msg);
  endtask

  function automatic void promote(input int slot);
    int unsigned r;
    r = line_rank[slot];
    for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
      if (line_valid[i] && line_rank[i] < r) line_rank[i]++;
    end
    line_rank[slot] = 0;
  endfunction

  task automatic cache_access(input lkv_pkg::op_t op, input logic [lkv_pkg::KEY_W-1:0] key,
                              input logic [lkv_pkg::VAL_W-1:0] val, output lookup_t res);
    int slot;
    int victim;
    int unsigned room;
    slot = -1;
    res = '{hit: 1'b0, data: MISS_DATA};
    for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
      if (slot < 0 && line_valid[i] && line_key[i] == key) slot = i;
    end
    if (slot >= 0) begin
      if (op == lkv_pkg::OP_PUT) line_val[slot] = val;
      else res = '{hit: 1'b1, data: line_val[slot]};
      promote(slot);
    end else if (op == lkv_pkg::OP_PUT) begin
      room = (capacity_reg == 0) ? 1 :
             (capacity_reg > lkv_pkg::ENTRIES) ? lkv_pkg::ENTRIES : capacity_reg;
      if (line_count >= room) begin
        victim = -1;
        for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
          if (line_valid[i] && (victim < 0 || line_rank[i] > line_rank[victim])) victim = i;
        end
        if (victim >= 0) begin
          line_valid[victim] = 1'b0;
          line_rank[victim] = 0;
          if (line_count > 0) line_count--;
        end
      end
      for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
        if (slot < 0 && !line_valid[i]) slot = i;
      end
      if (slot >= 0) begin
        for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
          if (line_valid[i]) line_rank[i]++;
        end
        line_valid[slot] = 1'b1;
        line_key[slot] = key;
        line_val[slot] = val;
        line_rank[slot] = 0;
        line_count++;
      end
    end
  endtask

  // Offer one beat and hold it until taken; expectations are queued at the accept edge.
  task automatic offer_beat(input access_t item);
    lookup_t res;
    if (!steady && $urandom_range(0, 99) < 12) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= item.op;
    s_tdata  <= {item.val, item.key};
    do @(posedge clk); while (s_tready !== 1'b1);
    cache_access(item.op, item.key, item.val, res);
    if (item.op == lkv_pkg::OP_GET) begin
      if (item.typed) res = '{hit: item.hit, data: item.data};
      pending_lookups.push_back(res);
    end
  endtask

  task automatic run_burst(input int count, input int span);
    access_t item;
    for (int n = 0; n < count; n++) begin
      item = '0;
      item.op  = lkv_pkg::op_t'($urandom_range(0, 1));
      item.key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, span - 1)];
      item.val = $urandom;
      offer_beat(item);
    end
  endtask

  // Drop valid and wait for every queued lookup to come back.
  task automatic drain_lookups();
    s_tvalid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
  endtask

  task automatic program_capacity(input logic [lkv_pkg::CAP_W-1:0] cap);
    logic [lkv_pkg::PDATA_W-1:0] readback;
    // a trailing put may still be updating the table
    repeat (6) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {lkv_pkg::REG_CAPACITY, 2'b00};
    pwdata  <= {(lkv_pkg::PDATA_W-lkv_pkg::CAP_W)'($urandom), cap};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    capacity_reg = cap;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[lkv_pkg::CAP_W-1:0] !== cap)
      log_fault($sformatf("capacity readback: expected %0d got %0d", cap,
                          readback[lkv_pkg::CAP_W-1:0]));
  endtask

  // result side: check taken beats, then pick the next ready level
  initial begin
    int hold_left;
    lookup_t want;
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid === 1'b1 && m_tready) begin
        if (pending_lookups.size() == 0) begin
          log_fault($sformatf("unexpected result beat: hit=%0b data=%08h", m_tuser, m_tdata));
        end else begin
          want = pending_lookups.pop_front();
          if (m_tuser !== want.hit)
            log_fault($sformatf("hit flag: expected %0b got %0b", want.hit, m_tuser));
          if (m_tdata !== want.data)
            log_fault($sformatf("data: expected %08h got %08h", want.data, m_tdata));
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) hold_left--;
      m_tready <= (hold_left == 0) && (steady || $urandom_range(0, 99) >= 9);
    end
  end

  always @(posedge clk) begin
    if (!rst && ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready) ||
                 (psel && penable && pready === 1'b1)))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
      line_valid[i] = 1'b0;
      line_key[i]   = '0;
      line_val[i]   = '0;
      line_rank[i]  = 0;
    end
    line_count   = 0;
    capacity_reg = lkv_pkg::CAPACITY_RESET;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int n = 0; n < SCRIPT_LEN; n++) offer_beat(SCRIPT[n]);
    run_burst(100, 20);
    drain_lookups();

    // lower below occupancy: nothing dropped until new keys arrive
    program_capacity(lkv_pkg::CAP_W'(0));
    run_burst(50, 3);
    drain_lookups();

    program_capacity(lkv_pkg::CAP_W'(31));
    run_burst(45, 20);
    hold_req = 1'b1;
    run_burst(45, 20);
    drain_lookups();

    program_capacity(lkv_pkg::CAP_W'(1));
    run_burst(40, 3);
    drain_lookups();

    program_capacity(lkv_pkg::CAP_W'(5));
    run_burst(30, 8);
    drain_lookups();
    run_burst(30, 8);
    drain_lookups();

    program_capacity(lkv_pkg::CAP_W'(16));
    steady = 1'b1;
    run_burst(60, 20);
    steady = 1'b0;
    drain_lookups();

    repeat (8) @(posedge clk);
    if (fault_count == 0 && pending_lookups.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/lkv_pkg.sv
src/lkv_ctrl.sv
src/lkv_datapath.sv
src/lru_key_value_cache.sv
bench/tb.sv
